// ----- rtl/core/txtcon_pkg.sv -----
// Package for the text console character engine: screen geometry, field widths,
// cell addressing helpers and the command and status structs between the controller and datapath.
// It depends on nothing else.
package txtcon_pkg;

	localparam int ROWS     = 25;
	localparam int COLS     = 80;
	localparam int TAB_SIZE = 8;

	localparam int CELLS  = ROWS * COLS;
	localparam int ROW_W  = $clog2(ROWS);
	localparam int COL_W  = $clog2(COLS);
	localparam int ADDR_W = $clog2(CELLS);
	localparam int CNT_W  = $clog2(TAB_SIZE + 1);

	localparam int KIND_W     = 3;
	localparam int CHAR_W     = 8;
	localparam int TROW_W     = 6;
	localparam int TCOL_W     = 7;
	localparam int OFFSET_W   = 13;
	localparam int CELL_W     = 16;
	localparam int S_TDATA_W  = 24;
	localparam int M_TDATA_W  = 48;

	localparam logic [KIND_W-1:0] KIND_PUT  = 3'd0;
	localparam logic [KIND_W-1:0] KIND_MOVE = 3'd1;
	localparam logic [KIND_W-1:0] KIND_CLS  = 3'd2;
	localparam logic [KIND_W-1:0] KIND_EOL  = 3'd3;
	localparam logic [KIND_W-1:0] KIND_READ = 3'd4;

	localparam logic [CHAR_W-1:0] CH_TAB   = 8'd9;
	localparam logic [CHAR_W-1:0] CH_NL    = 8'd10;
	localparam logic [CHAR_W-1:0] CH_SPACE = 8'd32;

	localparam logic [7:0] ATTR_RESET = 8'd7;

	typedef struct packed {
		logic latch;
		logic put_load;
		logic move;
		logic read;
		logic put;
		logic nl;
		logic clr_start;
		logic clr;
		logic wipe_start;
		logic wipe;
		logic out_load;
	} txtcon_cmd_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic              is_nl;
		logic              wrap;
		logic              scroll;
		logic              cnt_last;
		logic              cnt_zero;
		logic              clr_done;
		logic              wipe_done;
		logic              out_free;
	} txtcon_sts_t;

	// Spaces a tab writes from a given column.
	function automatic logic [CNT_W-1:0] tab_left(input logic [COL_W-1:0] col);
		logic [CNT_W-1:0] r;
		r = CNT_W'(TAB_SIZE);
		for (int i = 0; i < COLS; i++) begin
			if (col == COL_W'(i)) begin
				r = CNT_W'(TAB_SIZE - (i % TAB_SIZE));
			end
		end
		return r;
	endfunction

	// Physical row of a logical row under the ring offset of the top row.
	function automatic logic [ROW_W-1:0] phys_row(input logic [ROW_W-1:0] r,
			input logic [ROW_W-1:0] top);
		logic [ROW_W:0] s;
		s = {1'b0, r} + {1'b0, top};
		if (s >= (ROW_W + 1)'(ROWS)) begin
			s = s - (ROW_W + 1)'(ROWS);
		end
		return s[ROW_W-1:0];
	endfunction

	function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] prow,
			input logic [COL_W-1:0] col);
		return ADDR_W'(prow) * ADDR_W'(COLS) + ADDR_W'(col);
	endfunction

endpackage

// ----- rtl/core/txtcon_ctrl.sv -----
// Controller of the text console character engine: the state machine that sequences
// character writes, cursor moves, line clears, screen wipes and reads. Depends on txtcon_pkg.
module txtcon_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  txtcon_pkg::txtcon_sts_t sts,
	output txtcon_pkg::txtcon_cmd_t cmd
);
	import txtcon_pkg::*;

	typedef enum logic [3:0] {
		S_INIT,
		S_IDLE,
		S_DISP,
		S_PUT,
		S_NL,
		S_CLR,
		S_WIPE,
		S_RESULT
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   nl_pend_q;
	logic   nl_pend_d;

	assign s_tready = (state_q == S_IDLE);

	always_comb begin
		cmd       = '0;
		state_d   = state_q;
		nl_pend_d = nl_pend_q;
		case (state_q)
			S_INIT: begin
				cmd.wipe = 1'b1;
				if (sts.wipe_done) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (s_tvalid) begin
					cmd.latch = 1'b1;
					state_d   = S_DISP;
				end
			end
			S_DISP: begin
				case (sts.kind)
					KIND_PUT: begin
						cmd.put_load = 1'b1;
						if (sts.is_nl) begin
							cmd.clr_start = 1'b1;
							nl_pend_d     = 1'b1;
							state_d       = S_CLR;
						end else begin
							state_d = S_PUT;
						end
					end
					KIND_MOVE: begin
						cmd.move = 1'b1;
						state_d  = S_RESULT;
					end
					KIND_CLS: begin
						cmd.wipe_start = 1'b1;
						state_d        = S_WIPE;
					end
					KIND_EOL: begin
						cmd.clr_start = 1'b1;
						state_d       = S_CLR;
					end
					KIND_READ: begin
						cmd.read = 1'b1;
						state_d  = S_RESULT;
					end
					default: begin
						state_d = S_RESULT;
					end
				endcase
			end
			S_PUT: begin
				cmd.put = 1'b1;
				if (sts.wrap) begin
					state_d = S_NL;
				end else if (sts.cnt_last) begin
					state_d = S_RESULT;
				end
			end
			S_NL: begin
				cmd.nl = 1'b1;
				if (sts.scroll) begin
					state_d = S_CLR;
				end else if (sts.cnt_zero) begin
					state_d = S_RESULT;
				end else begin
					state_d = S_PUT;
				end
			end
			S_CLR: begin
				cmd.clr = 1'b1;
				if (sts.clr_done) begin
					if (nl_pend_q) begin
						nl_pend_d = 1'b0;
						state_d   = S_NL;
					end else if (sts.cnt_zero) begin
						state_d = S_RESULT;
					end else begin
						state_d = S_PUT;
					end
				end
			end
			S_WIPE: begin
				cmd.wipe = 1'b1;
				if (sts.wipe_done) begin
					state_d = S_RESULT;
				end
			end
			S_RESULT: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_INIT;
			nl_pend_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			nl_pend_q <= nl_pend_d;
		end
	end

endmodule

// ----- rtl/core/txtcon_dp.sv -----
// Datapath of the text console character engine: screen store, cursor and ring offset,
// sweep counters, attribute register and the result register. Depends on txtcon_pkg.
module txtcon_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic [txtcon_pkg::KIND_W-1:0]       s_tuser,
	input  logic [txtcon_pkg::S_TDATA_W-1:0]    s_tdata,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [txtcon_pkg::M_TDATA_W-1:0]    m_tdata,
	input  logic                                attr_we,
	input  logic [7:0]                          attr_wdata,
	input  txtcon_pkg::txtcon_cmd_t             cmd,
	output txtcon_pkg::txtcon_sts_t             sts
);
	import txtcon_pkg::*;

	logic [CELL_W-1:0]   mem [CELLS];
	logic [CELL_W-1:0]   rd_data_q;
	logic [KIND_W-1:0]   kind_q;
	logic [CHAR_W-1:0]   char_q;
	logic [TROW_W-1:0]   trow_q;
	logic [TCOL_W-1:0]   tcol_q;
	logic [CHAR_W-1:0]   put_char_q;
	logic [CNT_W-1:0]    cnt_q;
	logic                rej_q;
	logic                hit_q;
	logic [ROW_W-1:0]    cur_row_q;
	logic [COL_W-1:0]    cur_col_q;
	logic [ROW_W-1:0]    top_q;
	logic [COL_W-1:0]    sweep_col_q;
	logic [ADDR_W-1:0]   wipe_addr_q;
	logic [7:0]          text_attr_q;
	logic                m_tvalid_q;
	logic [M_TDATA_W-1:0] m_tdata_q;

	logic                tgt_ok;
	logic [ROW_W-1:0]    cur_prow;
	logic                mem_we;
	logic [ADDR_W-1:0]   mem_waddr;
	logic [CELL_W-1:0]   mem_wdata;
	logic [ADDR_W-1:0]   mem_raddr;
	logic [OFFSET_W-1:0] offset;
	logic [CELL_W-1:0]   rd_cell;

	assign tgt_ok = ({1'b0, trow_q} < (TROW_W + 1)'(ROWS))
		&& ({1'b0, tcol_q} < (TCOL_W + 1)'(COLS));
	assign cur_prow  = phys_row(cur_row_q, top_q);
	assign mem_raddr = cell_addr(phys_row(trow_q[ROW_W-1:0], top_q), tcol_q[COL_W-1:0]);

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = cell_addr(cur_prow, cur_col_q);
		mem_wdata = {text_attr_q, put_char_q};
		if (cmd.wipe) begin
			mem_we    = 1'b1;
			mem_waddr = wipe_addr_q;
			mem_wdata = '0;
		end else if (cmd.clr) begin
			mem_we    = 1'b1;
			mem_waddr = cell_addr(cur_prow, sweep_col_q);
			mem_wdata = '0;
		end else if (cmd.put) begin
			mem_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (cmd.read && tgt_ok) begin
			rd_data_q <= mem[mem_raddr];
		end
	end

	assign sts.kind      = kind_q;
	assign sts.is_nl     = (char_q == CH_NL);
	assign sts.wrap      = (cur_col_q == COL_W'(COLS - 1));
	assign sts.scroll    = (cur_row_q == ROW_W'(ROWS - 1));
	assign sts.cnt_last  = (cnt_q == CNT_W'(1));
	assign sts.cnt_zero  = (cnt_q == '0);
	assign sts.clr_done  = (sweep_col_q == COL_W'(COLS - 1));
	assign sts.wipe_done = (wipe_addr_q == ADDR_W'(CELLS - 1));
	assign sts.out_free  = !m_tvalid_q || m_tready;

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			kind_q <= s_tuser;
			char_q <= s_tdata[CHAR_W-1:0];
			trow_q <= s_tdata[CHAR_W +: TROW_W];
			tcol_q <= s_tdata[CHAR_W + TROW_W +: TCOL_W];
		end
		if (cmd.put_load) begin
			put_char_q <= (char_q == CH_TAB) ? CH_SPACE : char_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			rej_q       <= 1'b0;
			hit_q       <= 1'b0;
			cur_row_q   <= '0;
			cur_col_q   <= '0;
			top_q       <= '0;
			sweep_col_q <= '0;
			wipe_addr_q <= '0;
			text_attr_q <= ATTR_RESET;
		end else begin
			if (attr_we) begin
				text_attr_q <= attr_wdata;
			end
			if (cmd.latch) begin
				cnt_q <= '0;
				rej_q <= 1'b0;
				hit_q <= 1'b0;
			end
			if (cmd.put_load) begin
				if (char_q == CH_TAB) begin
					cnt_q <= tab_left(cur_col_q);
				end else if (char_q == CH_NL) begin
					cnt_q <= '0;
				end else begin
					cnt_q <= CNT_W'(1);
				end
			end
			if (cmd.move) begin
				if (tgt_ok) begin
					cur_row_q <= trow_q[ROW_W-1:0];
					cur_col_q <= tcol_q[COL_W-1:0];
				end else begin
					rej_q <= 1'b1;
				end
			end
			if (cmd.read) begin
				hit_q <= tgt_ok;
			end
			if (cmd.put) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (sts.wrap) begin
					cur_col_q <= '0;
				end else begin
					cur_col_q <= cur_col_q + COL_W'(1);
				end
			end
			if (cmd.nl) begin
				cur_col_q   <= '0;
				sweep_col_q <= '0;
				if (sts.scroll) begin
					top_q <= (top_q == ROW_W'(ROWS - 1)) ? '0 : top_q + ROW_W'(1);
				end else begin
					cur_row_q <= cur_row_q + ROW_W'(1);
				end
			end
			if (cmd.clr_start) begin
				sweep_col_q <= cur_col_q;
			end
			if (cmd.clr) begin
				sweep_col_q <= sweep_col_q + COL_W'(1);
			end
			if (cmd.wipe_start) begin
				wipe_addr_q <= '0;
				top_q       <= '0;
				cur_row_q   <= '0;
				cur_col_q   <= '0;
			end
			if (cmd.wipe) begin
				wipe_addr_q <= wipe_addr_q + ADDR_W'(1);
			end
		end
	end

	assign offset  = OFFSET_W'(cur_row_q) * OFFSET_W'(COLS) + OFFSET_W'(cur_col_q);
	assign rd_cell = hit_q ? rd_data_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd.out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			m_tdata_q <= {5'b0, rej_q, rd_cell[15:8], rd_cell[7:0], offset,
				TCOL_W'(cur_col_q), TROW_W'(cur_row_q)};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

// ----- rtl/core/text_console_char_engine.sv -----
// Top level of the text console character engine: joins the controller and the datapath.
// Depends on txtcon_pkg, txtcon_ctrl and txtcon_dp.
//
// Commands enter on the slave stream: s_tuser carries the kind, s_tdata the character and
// the target row and column. Each transaction yields exactly one result transaction on
// the master stream with the cursor position, its linear offset, the cell read and the
// rejection flag. The attribute register is written through attr_we and attr_wdata.
// One command is worked on at a time. A plain character passes the dispatch and write
// states before its result is loaded; a move, a read or an unused kind goes from dispatch
// to the result. The next command can be accepted in the cycle after the result is loaded.
// A tab writes spaces up to the next tab stop. A clear to end of line clears each cell
// from the cursor to the end of the row; a newline does the same, then takes the line step.
// A wrap adds the line step, and a scroll clears the new bottom row cell by cell, as the
// screen store has a single write port. A clear screen walks every cell once.
// After reset the same walk clears all ROWS*COLS cells of the store (2000 as built);
// s_tready stays low until it ends. The cursor, ring offset and attribute (7) are reset.
// The result register lets the next command be accepted while a result waits; if the
// receiver stalls, the following result is held in the engine until the register frees.
module text_console_char_engine (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// kind
	input  logic [txtcon_pkg::KIND_W-1:0]       s_tuser,
	// char_code [7:0], target_row [13:8], target_col [20:14], zero fill above
	input  logic [txtcon_pkg::S_TDATA_W-1:0]    s_tdata,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// cursor_row [5:0], cursor_col [12:6], cursor_offset [25:13], cell_char [33:26],
	// cell_attr [41:34], move_rejected [42], zero fill above
	output logic [txtcon_pkg::M_TDATA_W-1:0]    m_tdata,
	input  logic                                attr_we,
	input  logic [7:0]                          attr_wdata
);
	import txtcon_pkg::*;

	txtcon_cmd_t cmd;
	txtcon_sts_t sts;

	txtcon_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	txtcon_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tuser    (s_tuser),
		.s_tdata    (s_tdata),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.attr_we    (attr_we),
		.attr_wdata (attr_wdata),
		.cmd        (cmd),
		.sts        (sts)
	);

endmodule
